// ----- rtl/edf_pkg.sv -----
// Shared types and constants for the EDF task table.
// Item layouts, table entry layout, status and operation codes, sequencer states.
// No dependencies.
package edf_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic OP_RELEASE  = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [15:0] task_id;
    logic [31:0] deadline;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        overdue;
    logic [31:0] release_tick;
    logic        running_valid;
    logic [15:0] running_id;
    logic [31:0] running_deadline;
    logic [4:0]  active_count;
    logic [31:0] completed_count;
    logic [31:0] overdue_count;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] deadline;
    logic [31:0] released;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_WRNEW,
    S_HEAD,
    S_RESULT
  } state_t;

endpackage

// ----- rtl/edf_task_table.sv -----
// Earliest-deadline-first task table: sorted entry memory walked by a small sequencer.
// Depends on edf_pkg.
//
// Sequence: a release walks down from the tail, moving later deadlines up, and writes the
// new entry; a complete walks up from the head to find and remove the id; a full table, an
// empty-table release or completion skips the walk. Each then reads the head and waits on out_ready.
// Throughput: one item at a time; the entry memory (one read port and one write port, one read, one write a
// cycle) and the one 32-bit comparator bound the walk to one entry a cycle.
// Reset: rst (synchronous) clears the sequencer, the task count, both totals and out_valid;
// entry memory keeps its contents, since only entries below the count are ever used.
module edf_task_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  edf_pkg::in_t   in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output edf_pkg::out_t  out_item
);
  import edf_pkg::*;

  // Sequencer and latched item
  state_t      state, state_next;
  in_t         cur;
  idx_t        k, k_next;
  idx_t        last;
  cnt_t        count, count_next;
  logic        found, found_next;
  logic [1:0]  status, status_next;
  logic        late, late_next;
  logic [31:0] rel, rel_next;
  logic [31:0] on_time_tot, on_time_tot_next;
  logic [31:0] late_tot, late_tot_next;
  logic        accept;
  logic        load_out;
  logic        match;

  // Entry memory: one write port, one registered read port
  entry_t      mem [SLOTS];
  idx_t        rd_addr;
  entry_t      rdata;
  logic        we;
  idx_t        wr_addr;
  entry_t      wdata;
  entry_t      new_entry;

  // Shared comparator: deadline ordering on release, lateness on complete
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_gt;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state == S_RESULT) && (!out_valid || out_ready);
  assign last      = idx_t'(count - cnt_t'(1));
  assign match     = !found && (rdata.id == cur.task_id);
  assign new_entry = '{id: cur.task_id, deadline: cur.deadline, released: cur.now};

  always_comb begin
    if (cur.operation == OP_RELEASE) begin
      cmp_a = rdata.deadline;
      cmp_b = cur.deadline;
    end else begin
      cmp_a = cur.now;
      cmp_b = rdata.deadline;
    end
    cmp_gt = cmp_a > cmp_b;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_item.operation == OP_RELEASE) begin
            if (count == cnt_t'(SLOTS)) begin
              state_next = S_HEAD;
            end else if (count == '0) begin
              state_next = S_WRNEW;
            end else begin
              state_next = S_LOOP;
            end
          end else begin
            state_next = (count == '0) ? S_HEAD : S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (cur.operation == OP_RELEASE) begin
          if (cmp_gt) begin
            state_next = (k == idx_t'(1)) ? S_WRNEW : S_LOOP;
          end else begin
            state_next = S_HEAD;
          end
        end else begin
          state_next = (k == last) ? S_HEAD : S_LOOP;
        end
      end
      S_WRNEW:  state_next = S_HEAD;
      S_HEAD:   state_next = S_RESULT;
      S_RESULT: state_next = load_out ? S_IDLE : S_RESULT;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    k_next           = k;
    count_next       = count;
    found_next       = found;
    status_next      = status;
    late_next        = late;
    rel_next         = rel;
    on_time_tot_next = on_time_tot;
    late_tot_next    = late_tot;
    rd_addr          = '0;
    we               = 1'b0;
    wr_addr          = k;
    wdata            = rdata;
    case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = ST_OK;
          late_next   = 1'b0;
          rel_next    = '0;
          found_next  = 1'b0;
          k_next      = '0;
          if (in_item.operation == OP_RELEASE) begin
            if (count == cnt_t'(SLOTS)) begin
              status_next = ST_FULL;
            end else if (count != '0) begin
              // walk down from the tail, moving later deadlines up by one
              rd_addr = last;
              k_next  = idx_t'(count);
            end
          end else begin
            if (count == '0) begin
              status_next = ST_NOT_FOUND;
            end
          end
        end
      end
      S_LOOP: begin
        if (cur.operation == OP_RELEASE) begin
          we      = 1'b1;
          wr_addr = k;
          if (cmp_gt) begin
            wdata   = rdata;
            rd_addr = k - idx_t'(2);
            k_next  = k - idx_t'(1);
          end else begin
            wdata      = new_entry;
            count_next = count + cnt_t'(1);
          end
        end else begin
          if (match) begin
            found_next = 1'b1;
            rel_next   = rdata.released;
            late_next  = cmp_gt;
            if (cmp_gt) begin
              late_tot_next = late_tot + 32'd1;
            end else begin
              on_time_tot_next = on_time_tot + 32'd1;
            end
          end else if (found) begin
            // close the gap behind the removed entry
            we      = 1'b1;
            wr_addr = k - idx_t'(1);
            wdata   = rdata;
          end
          if (k == last) begin
            if (found || match) begin
              count_next = count - cnt_t'(1);
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end else begin
            rd_addr = k + idx_t'(1);
            k_next  = k + idx_t'(1);
          end
        end
      end
      S_WRNEW: begin
        we         = 1'b1;
        wr_addr    = k;
        wdata      = new_entry;
        count_next = count + cnt_t'(1);
      end
      S_HEAD: begin
        rd_addr = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      on_time_tot <= '0;
      late_tot    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      on_time_tot <= on_time_tot_next;
      late_tot    <= late_tot_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= in_item;
    end
    k      <= k_next;
    found  <= found_next;
    status <= status_next;
    late   <= late_next;
    rel    <= rel_next;
    if (load_out) begin
      out_item.status          <= status;
      out_item.overdue         <= late;
      out_item.release_tick    <= rel;
      out_item.running_valid   <= (count != '0);
      out_item.active_count    <= 5'(count);
      out_item.completed_count <= on_time_tot;
      out_item.overdue_count   <= late_tot;
      if (count != '0) begin
        out_item.running_id       <= rdata.id;
        out_item.running_deadline <= rdata.deadline;
      end else begin
        out_item.running_id       <= '0;
        out_item.running_deadline <= '0;
      end
    end
  end

endmodule

// ----- tb/edf_task_table_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for edf_task_table: releases and completes tasks through the
// valid/ready channels and checks each result item against a deadline-ordered tracker.
// Depends on edf_pkg and edf_task_table.
module edf_task_table_test;
  import edf_pkg::*;

  localparam int RANDOM_ITEMS = 1825;
  // The longest quiet stretch in a correct run is the forced receiver hold-off plus one
  // slow item and both idle gaps. Allow several times that.
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;
  // The slowest items walk the whole table between accept and result.
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] deadline;
    logic [31:0] released_at;
  } slot_t;

  // Tracks the active tasks in deadline order and the expected result items.
  class deadline_order_tracker;
    slot_t       slots[$];
    logic [31:0] on_time_total;
    logic [31:0] late_total;
    out_t        expected_results[$];
    int          mismatches;

    function new();
      on_time_total = '0;
      late_total    = '0;
      mismatches    = 0;
    endfunction

    // Apply one accepted item to the table and queue the result it must produce.
    function void note_item(in_t it);
      out_t  r;
      slot_t s;
      int    pos;
      r   = '0;
      pos = 0;
      if (it.operation == OP_RELEASE) begin
        if (slots.size() >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          // Equal deadlines go behind existing entries.
          while (pos < slots.size() && slots[pos].deadline <= it.deadline) pos++;
          s.id          = it.task_id;
          s.deadline    = it.deadline;
          s.released_at = it.now;
          slots.insert(pos, s);
          r.status = ST_OK;
        end
      end else begin
        while (pos < slots.size() && slots[pos].id != it.task_id) pos++;
        if (pos >= slots.size()) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status       = ST_OK;
          r.release_tick = slots[pos].released_at;
          if (it.now > slots[pos].deadline) begin
            r.overdue  = 1'b1;
            late_total = late_total + 1;
          end else begin
            on_time_total = on_time_total + 1;
          end
          slots.delete(pos);
        end
      end
      if (slots.size() > 0) begin
        r.running_valid    = 1'b1;
        r.running_id       = slots[0].id;
        r.running_deadline = slots[0].deadline;
      end
      r.active_count    = 5'(slots.size());
      r.completed_count = on_time_total;
      r.overdue_count   = late_total;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result item with nothing expected: expected none, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("overdue", want.overdue, got.overdue);
      compare_field("release_tick", want.release_tick, got.release_tick);
      compare_field("running_valid", want.running_valid, got.running_valid);
      compare_field("running_id", want.running_id, got.running_id);
      compare_field("running_deadline", want.running_deadline, got.running_deadline);
      compare_field("active_count", want.active_count, got.active_count);
      compare_field("completed_count", want.completed_count, got.completed_count);
      compare_field("overdue_count", want.overdue_count, got.overdue_count);
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  in_t  in_item   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_item;

  deadline_order_tracker tracker = new();

  // Shared pacing controls, set by the sender.
  bit quiet_phase   = 1'b0;  // both sides run without idle gaps
  bit long_hold_req = 1'b0;  // receiver takes the long LONG_HOLD stall once
  int idle_cycles   = 0;

  edf_task_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_t make_item(logic op, logic [15:0] id, logic [31:0] dl,
                                    logic [31:0] now);
    in_t it;
    it.operation = op;
    it.task_id   = id;
    it.deadline  = dl;
    it.now       = now;
    return it;
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic send_item(in_t it);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(it);
  endtask

  // Sender: directed items first, then random traffic.
  initial begin
    in_t         directed[$];
    in_t         it;
    logic [31:0] tick;
    int          live;
    int          roll;
    int          pick;
    int          release_pct;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Complete on an empty table.
    directed.push_back(make_item(OP_COMPLETE, 16'h1234, 32'h0, 32'h0));
    // Field extremes.
    directed.push_back(make_item(OP_RELEASE, 16'h0000, 32'h0, 32'h0));
    directed.push_back(make_item(OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Equal deadlines must keep arrival order; id 5 appears twice.
    directed.push_back(make_item(OP_RELEASE, 16'd5, 32'd100, 32'd10));
    directed.push_back(make_item(OP_RELEASE, 16'd6, 32'd100, 32'd11));
    directed.push_back(make_item(OP_RELEASE, 16'd5, 32'd50, 32'd12));
    directed.push_back(make_item(OP_RELEASE, 16'd7, 32'd100, 32'd13));
    // Fill the table up to the last slot.
    for (int k = 0; k < 10; k++)
      directed.push_back(make_item(OP_RELEASE, 16'h5A00 + 16'(k), 32'h8000_0000 + k,
                                   32'd20 + k));
    // Release into a full table.
    directed.push_back(make_item(OP_RELEASE, 16'h7777, 32'd1, 32'd30));
    // Unknown id.
    directed.push_back(make_item(OP_COMPLETE, 16'h4242, 32'h0, 32'd31));
    // Duplicate id: the earlier deadline goes first, completed exactly at its deadline.
    directed.push_back(make_item(OP_COMPLETE, 16'd5, 32'h0, 32'd50));
    // Late by one tick.
    directed.push_back(make_item(OP_COMPLETE, 16'd5, 32'h0, 32'd101));
    directed.push_back(make_item(OP_COMPLETE, 16'h0000, 32'h0, 32'd1));
    directed.push_back(make_item(OP_COMPLETE, 16'hFFFF, 32'h0, 32'hFFFF_FFFF));
    directed.push_back(make_item(OP_COMPLETE, 16'd6, 32'h0, 32'd0));

    foreach (directed[k]) send_item(directed[k]);

    tick        = $urandom;
    release_pct = 75;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      // Alternate filling and draining phases so the table hits full and empty often.
      if (n % 64 == 0) release_pct = $urandom_range(0, 1) ? 75 : 40;
      // Back up the output: receiver stalls while we keep offering items.
      if (n == 600) long_hold_req = 1'b1;
      // Pause until every outstanding result has drained.
      if (n == 1200) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_results.size() != 0) @(posedge clk);
      end

      live = tracker.slots.size();
      roll = $urandom_range(0, 99);
      it   = '0;
      if (roll < 10) begin
        // Noise: any operation, any id; completions here mostly miss.
        it.operation = 1'($urandom_range(0, 1));
        it.task_id   = 16'($urandom);
        it.deadline  = $urandom;
        it.now       = $urandom;
      end else if (live == 0 || (live < SLOTS && roll < release_pct) ||
                   (live == SLOTS && roll < 14)) begin
        it.operation = OP_RELEASE;
        // Draw from a small id pool now and then to get duplicate ids.
        it.task_id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7))
                                                 : 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
          it.deadline = $urandom;
        else if (pick < 3 && live > 0)
          it.deadline = tracker.slots[$urandom_range(0, live - 1)].deadline;  // tie
        else
          it.deadline = tick + $urandom_range(0, 2000);
        it.now = tick;
        tick   = tick + $urandom_range(0, 300);
      end else begin
        // Complete a live task, on time, exactly at deadline, late, or at a random tick.
        it.operation = OP_COMPLETE;
        pick         = $urandom_range(0, live - 1);
        it.task_id   = tracker.slots[pick].id;
        roll         = $urandom_range(0, 9);
        if (roll == 0)
          it.now = tracker.slots[pick].deadline;
        else if (roll < 5)
          it.now = tracker.slots[pick].deadline - $urandom_range(0, 500);
        else if (roll < 9)
          it.now = tracker.slots[pick].deadline + $urandom_range(1, 500);
        else
          it.now = $urandom;
        it.deadline = $urandom;
      end
      send_item(it);
    end
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before each result item.
  initial begin
    int gap;
    bit long_hold_done;
    long_hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        gap            = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        gap = quiet_phase ? 0 : $urandom_range(0, 14);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_item);
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

endmodule
